// ===== rtl/core/i2cm_pkg.sv =====
`timescale 1ns / 1ps

package i2cm_pkg;

    // Command codes carried by the mode field of a tick.
    localparam logic [2:0] MODE_NONE      = 3'd0;
    localparam logic [2:0] MODE_START     = 3'd1;
    localparam logic [2:0] MODE_STOP      = 3'd2;
    localparam logic [2:0] MODE_WRITE     = 3'd3;
    localparam logic [2:0] MODE_READ_ACK  = 3'd4;
    localparam logic [2:0] MODE_READ_NACK = 3'd5;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_HALF   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ACK_HALF   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_STOP = 2'd2;

    localparam logic [7:0] BIT_HALF_RST   = 8'd1;
    localparam logic [7:0] ACK_HALF_RST   = 8'd2;
    localparam logic [7:0] START_STOP_RST = 8'd4;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [7:0] bit_half_ticks;
        logic [7:0] ack_half_ticks;
        logic [7:0] start_stop_hold_ticks;
    } cfg_t;

    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_bit;
    } res_t;

    // A programmed duration of zero still lasts one tick.
    function automatic logic [7:0] dur(input logic [7:0] v);
        dur = (v == 8'd0) ? 8'd1 : v;
    endfunction

endpackage

// ===== rtl/core/i2cm_if.sv =====
`timescale 1ns / 1ps

interface i2cm_tick_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode;
    logic [7:0] tx_byte;
    logic       sda_in;

    modport source (output valid, mode, tx_byte, sda_in, input ready);
    modport sink (input valid, mode, tx_byte, sda_in, output ready);
endinterface

interface i2cm_res_if;
    logic       valid;
    logic       ready;
    logic       scl_out;
    logic       sda_out;
    logic       sda_drive;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_bit;

    modport source (output valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                    rx_byte, ack_bit, input ready);
    modport sink (input valid, scl_out, sda_out, sda_drive, busy_res, done_res,
                  rx_byte, ack_bit, output ready);
endinterface

interface i2cm_cfg_if;
    logic       valid;
    logic       ready;
    logic [1:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/i2cm_cfg_regs.sv =====
`timescale 1ns / 1ps

module i2cm_cfg_regs
    import i2cm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [CFG_IDX_W-1:0] wr_index,
    input  logic [7:0]           wr_data,
    output cfg_t                 cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                CFG_BIT_HALF:   cfg_next.bit_half_ticks        = wr_data;
                CFG_ACK_HALF:   cfg_next.ack_half_ticks        = wr_data;
                CFG_START_STOP: cfg_next.start_stop_hold_ticks = wr_data;
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.bit_half_ticks        <= BIT_HALF_RST;
            cfg_reg.ack_half_ticks        <= ACK_HALF_RST;
            cfg_reg.start_stop_hold_ticks <= START_STOP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/core/i2cm_core.sv =====
`timescale 1ns / 1ps

module i2cm_core
    import i2cm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       tick_en,
    input  logic [2:0] mode,
    input  logic [7:0] tx_byte,
    input  logic       sda_in,
    input  cfg_t       cfg,
    output res_t       res_next
);

    typedef enum logic [3:0] {
        PH_IDLE, PH_ST_HIGH, PH_ST_LOW, PH_SP_LOW, PH_SP_HIGH,
        PH_WR_LOW, PH_WR_HIGH, PH_WA_LOW, PH_WA_HIGH,
        PH_RD_LOW, PH_RD_HIGH, PH_RA_LOW, PH_RA_HIGH
    } phase_t;

    phase_t     phase_reg, phase_next;
    logic [7:0] tick_reg, tick_next;
    logic [3:0] bit_reg, bit_next;
    logic [7:0] shift_reg, shift_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       sda_en_reg, sda_en_next;
    logic       ack_reg, ack_next;
    logic       rd_nack_reg, rd_nack_next;
    logic [7:0] rx_reg, rx_next;
    logic       done;

    logic [7:0] tick_inc;
    logic [3:0] bit_inc;
    logic [7:0] phase_len;
    logic [7:0] rd_shift;

    assign tick_inc = tick_reg + 8'd1;
    assign bit_inc  = bit_reg + 4'd1;
    assign rd_shift = {shift_reg[6:0], sda_in};

    always_comb
    begin
        case (phase_reg)
            PH_ST_HIGH, PH_ST_LOW, PH_SP_LOW: phase_len = dur(cfg.start_stop_hold_ticks);
            PH_SP_HIGH:                       phase_len = 8'd1;
            PH_RA_LOW, PH_RA_HIGH:            phase_len = dur(cfg.ack_half_ticks);
            default:                          phase_len = dur(cfg.bit_half_ticks);
        endcase
    end

    always_comb
    begin
        phase_next   = phase_reg;
        tick_next    = tick_reg;
        bit_next     = bit_reg;
        shift_next   = shift_reg;
        scl_next     = scl_reg;
        sda_next     = sda_reg;
        sda_en_next  = sda_en_reg;
        ack_next     = ack_reg;
        rd_nack_next = rd_nack_reg;
        rx_next      = rx_reg;
        done         = 1'b0;

        // A phase code beyond the last defined phase is handled as idle.
        if (phase_reg == PH_IDLE || phase_reg > PH_RA_HIGH)
        begin
            tick_next = 8'd0;
            bit_next  = 4'd0;
            case (mode)
                MODE_START:
                begin
                    sda_en_next = 1'b1;
                    sda_next    = 1'b1;
                    scl_next    = 1'b1;
                    phase_next  = PH_ST_HIGH;
                end
                MODE_STOP:
                begin
                    sda_en_next = 1'b1;
                    scl_next    = 1'b0;
                    sda_next    = 1'b0;
                    phase_next  = PH_SP_LOW;
                end
                MODE_WRITE:
                begin
                    sda_en_next = 1'b1;
                    sda_next    = tx_byte[7];
                    shift_next  = {tx_byte[6:0], 1'b0};
                    scl_next    = 1'b0;
                    phase_next  = PH_WR_LOW;
                end
                MODE_READ_ACK, MODE_READ_NACK:
                begin
                    rd_nack_next = (mode == MODE_READ_NACK);
                    sda_en_next  = 1'b0;
                    scl_next     = 1'b0;
                    shift_next   = 8'd0;
                    phase_next   = PH_RD_LOW;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        else
        begin
            tick_next = tick_inc;
            if (tick_inc >= phase_len)
            begin
                tick_next = 8'd0;
                case (phase_reg)
                    PH_ST_HIGH:
                    begin
                        sda_next   = 1'b0;
                        phase_next = PH_ST_LOW;
                    end
                    PH_SP_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_SP_HIGH;
                    end
                    PH_SP_HIGH:
                    begin
                        sda_next = 1'b1;
                        done     = 1'b1;
                    end
                    PH_WR_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_WR_HIGH;
                    end
                    PH_WR_HIGH:
                    begin
                        bit_next = bit_inc;
                        scl_next = 1'b0;
                        if (bit_inc >= BITS_PER_BYTE)
                        begin
                            sda_en_next = 1'b0;
                            phase_next  = PH_WA_LOW;
                        end
                        else
                        begin
                            sda_next   = shift_reg[7];
                            shift_next = {shift_reg[6:0], 1'b0};
                            phase_next = PH_WR_LOW;
                        end
                    end
                    PH_WA_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_WA_HIGH;
                    end
                    PH_WA_HIGH:
                    begin
                        ack_next    = sda_in;
                        scl_next    = 1'b0;
                        sda_en_next = 1'b1;
                        done        = 1'b1;
                    end
                    PH_RD_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_RD_HIGH;
                    end
                    PH_RD_HIGH:
                    begin
                        shift_next = rd_shift;
                        bit_next   = bit_inc;
                        scl_next   = 1'b0;
                        if (bit_inc >= BITS_PER_BYTE)
                        begin
                            rx_next     = rd_shift;
                            sda_en_next = 1'b1;
                            sda_next    = rd_nack_reg;
                            phase_next  = PH_RA_LOW;
                        end
                        else
                        begin
                            phase_next = PH_RD_LOW;
                        end
                    end
                    PH_RA_LOW:
                    begin
                        scl_next   = 1'b1;
                        phase_next = PH_RA_HIGH;
                    end
                    default:
                    begin
                        // End of start hold or of the master acknowledge.
                        scl_next = 1'b0;
                        done     = 1'b1;
                    end
                endcase
                if (done)
                begin
                    phase_next = PH_IDLE;
                    bit_next   = 4'd0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            tick_reg    <= 8'd0;
            bit_reg     <= 4'd0;
            shift_reg   <= 8'd0;
            scl_reg     <= 1'b1;
            sda_reg     <= 1'b1;
            sda_en_reg  <= 1'b1;
            ack_reg     <= 1'b0;
            rd_nack_reg <= 1'b0;
            rx_reg      <= 8'd0;
        end
        else if (tick_en)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_reg     <= bit_next;
            shift_reg   <= shift_next;
            scl_reg     <= scl_next;
            sda_reg     <= sda_next;
            sda_en_reg  <= sda_en_next;
            ack_reg     <= ack_next;
            rd_nack_reg <= rd_nack_next;
            rx_reg      <= rx_next;
        end
    end

    always_comb
    begin
        res_next.scl_out   = scl_next;
        res_next.sda_out   = sda_next;
        res_next.sda_drive = sda_en_next;
        res_next.busy_res  = (phase_next != PH_IDLE);
        res_next.done_res  = done;
        res_next.rx_byte   = rx_next;
        res_next.ack_bit   = ack_next;
    end

endmodule

// ===== rtl/core/i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps
// Latency: the result of a tick is valid on the cycle after the tick transfer.
// Throughput: one tick per cycle; the only limit is the single output register,
// which takes a new result whenever it is empty or being drained the same cycle.
// Reset (rst_n, asynchronous, active low): the engine goes idle with SCL and SDA
// high and driven, and the timing registers return to 1, 2 and 4 ticks.

module i2c_master_bit_engine_unit
    import i2cm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    i2cm_tick_if.sink   tick,
    i2cm_res_if.source  res,
    i2cm_cfg_if.sink    cfg
);

    cfg_t cfg_cur;
    res_t res_next;
    res_t res_data_reg;
    logic res_valid_reg;
    logic tick_fire;

    // Configuration writes are always taken; writes to an unused index are dropped.
    assign cfg.ready = 1'b1;

    i2cm_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg.valid),
        .wr_index (cfg.index),
        .wr_data  (cfg.data),
        .cfg      (cfg_cur)
    );

    // A tick moves in whenever the output register is empty or is handing its
    // result over in this same cycle, so the engine advances one tick per cycle
    // as long as the consumer keeps up.
    assign tick.ready = !res_valid_reg || res.ready;
    assign tick_fire  = tick.valid && tick.ready;

    // The core holds the bus state and computes each tick's outcome in one pass.
    i2cm_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .tick_en  (tick_fire),
        .mode     (tick.mode),
        .tx_byte  (tick.tx_byte),
        .sda_in   (tick.sda_in),
        .cfg      (cfg_cur),
        .res_next (res_next)
    );

    // Output register: one result per tick transfer, held until it is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (tick_fire)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick_fire)
        begin
            res_data_reg <= res_next;
        end
    end

    assign res.valid     = res_valid_reg;
    assign res.scl_out   = res_data_reg.scl_out;
    assign res.sda_out   = res_data_reg.sda_out;
    assign res.sda_drive = res_data_reg.sda_drive;
    assign res.busy_res  = res_data_reg.busy_res;
    assign res.done_res  = res_data_reg.done_res;
    assign res.rx_byte   = res_data_reg.rx_byte;
    assign res.ack_bit   = res_data_reg.ack_bit;

endmodule

// ===== rtl/core/i2cm_checker.sv =====
`timescale 1ns / 1ps

module i2cm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       tick_valid,
    input logic       tick_ready,
    input logic       res_valid,
    input logic       res_ready,
    input logic       sda_drive,
    input logic       busy_res,
    input logic       done_res,
    input logic [7:0] rx_byte
);

    // Every tick transfer yields a result in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |=> res_valid)
    else $error("tick transfer produced no result");

    // A finishing tick never reports the engine as still busy.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && done_res |-> !busy_res)
    else $error("done and busy reported together");

    // SDA is released only in the middle of a command.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !sda_drive |-> busy_res)
    else $error("SDA released while idle");

    // A stalled result holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(rx_byte) && $stable(done_res))
    else $error("stalled result changed");

endmodule

bind i2c_master_bit_engine_unit i2cm_checker u_i2cm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_valid (tick.valid),
    .tick_ready (tick.ready),
    .res_valid  (res.valid),
    .res_ready  (res.ready),
    .sda_drive  (res.sda_drive),
    .busy_res   (res.busy_res),
    .done_res   (res.done_res),
    .rx_byte    (res.rx_byte)
);

// ===== bench/tb_i2c_master_bit_engine_unit.sv =====
`timescale 1ns / 1ps

module tb_i2c_master_bit_engine_unit;
    import i2cm_pkg::*;

    // Register index that the block does not implement; writes to it must be dropped.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    // Mode codes outside the command set. The engine treats them as no command.
    localparam logic [2:0] MODE_SPARE_LO = 3'd6;
    localparam logic [2:0] MODE_SPARE_HI = 3'd7;

    // Cycles without any transfer on any channel before the run is declared hung.
    // The longest legal quiet stretch is the receiver hold-off, and each side's
    // random gaps are far shorter than that, so this leaves a wide margin.
    localparam int unsigned HANG_LIMIT = 4000;
    localparam int unsigned RECEIVER_HOLD = 300;
    localparam int unsigned HOLD_AFTER_RESULTS = 250;
    localparam int unsigned RANDOM_TICKS_PER_PHASE = 200;

    // How the simulated bus answers on sda_in while a command runs.
    typedef enum logic [1:0] {
        SDA_RANDOM,
        SDA_ALL_LOW,
        SDA_ALL_HIGH
    } sda_policy_e;

    // Engine sequencing steps, tracked inside the predictor.
    typedef enum logic [3:0] {
        ENG_IDLE,
        ENG_ST_HIGH,
        ENG_ST_LOW,
        ENG_SP_LOW,
        ENG_SP_HIGH,
        ENG_WR_LOW,
        ENG_WR_HIGH,
        ENG_WA_LOW,
        ENG_WA_HIGH,
        ENG_RD_LOW,
        ENG_RD_HIGH,
        ENG_RA_LOW,
        ENG_RA_HIGH
    } eng_phase_e;

    // The scoreboard mirrors the engine tick by tick. Every accepted tick yields
    // exactly one set of line levels, which is queued until the matching result
    // transfer comes out of the block.
    class bus_line_tracker;
        logic [7:0] bit_half;
        logic [7:0] ack_half;
        logic [7:0] hold_ticks;

        eng_phase_e ph;
        logic [7:0] tick_cnt;
        logic [3:0] bits_done;
        logic [7:0] shifter;
        logic       scl;
        logic       sda;
        logic       sda_en;
        logic       ack_seen;
        logic       nack_after_read;
        logic [7:0] rx_last;

        res_t        lines_due[$];
        int unsigned ticks_noted;
        int unsigned fail_count;

        function new();
            bit_half        = BIT_HALF_RST;
            ack_half        = ACK_HALF_RST;
            hold_ticks      = START_STOP_RST;
            ph              = ENG_IDLE;
            tick_cnt        = 8'd0;
            bits_done       = 4'd0;
            shifter         = 8'd0;
            scl             = 1'b1;
            sda             = 1'b1;
            sda_en          = 1'b1;
            ack_seen        = 1'b0;
            nack_after_read = 1'b0;
            rx_last         = 8'd0;
            ticks_noted     = 0;
            fail_count      = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [7:0] val);
            case (idx)
                CFG_BIT_HALF:   bit_half = val;
                CFG_ACK_HALF:   ack_half = val;
                CFG_START_STOP: hold_ticks = val;
                default:        ;
            endcase
        endfunction

        function logic [7:0] at_least_one(logic [7:0] v);
            return (v == 8'd0) ? 8'd1 : v;
        endfunction

        function logic [7:0] half_len();
            case (ph)
                ENG_ST_HIGH, ENG_ST_LOW, ENG_SP_LOW: return at_least_one(hold_ticks);
                ENG_SP_HIGH:                         return 8'd1;
                ENG_RA_LOW, ENG_RA_HIGH:             return at_least_one(ack_half);
                default:                             return at_least_one(bit_half);
            endcase
        endfunction

        // Present the MSB of the shifter on SDA while SCL is low.
        function void load_next_bit();
            sda     = shifter[7];
            shifter = {shifter[6:0], 1'b0};
            scl     = 1'b0;
            ph      = ENG_WR_LOW;
        endfunction

        // Leave the current step; returns 1 when the command is complete.
        function bit step_phase(logic sda_now);
            case (ph)
                ENG_ST_HIGH:
                begin
                    sda = 1'b0;
                    ph  = ENG_ST_LOW;
                end
                ENG_ST_LOW:
                begin
                    scl = 1'b0;
                    return 1'b1;
                end
                ENG_SP_LOW:
                begin
                    scl = 1'b1;
                    ph  = ENG_SP_HIGH;
                end
                ENG_SP_HIGH:
                begin
                    sda = 1'b1;
                    return 1'b1;
                end
                ENG_WR_LOW:
                begin
                    scl = 1'b1;
                    ph  = ENG_WR_HIGH;
                end
                ENG_WR_HIGH:
                begin
                    bits_done = bits_done + 4'd1;
                    if (bits_done >= BITS_PER_BYTE)
                    begin
                        scl    = 1'b0;
                        sda_en = 1'b0;
                        ph     = ENG_WA_LOW;
                    end
                    else
                    begin
                        load_next_bit();
                    end
                end
                ENG_WA_LOW:
                begin
                    scl = 1'b1;
                    ph  = ENG_WA_HIGH;
                end
                ENG_WA_HIGH:
                begin
                    ack_seen = sda_now;
                    scl      = 1'b0;
                    sda_en   = 1'b1;
                    return 1'b1;
                end
                ENG_RD_LOW:
                begin
                    scl = 1'b1;
                    ph  = ENG_RD_HIGH;
                end
                ENG_RD_HIGH:
                begin
                    shifter   = {shifter[6:0], sda_now};
                    bits_done = bits_done + 4'd1;
                    scl       = 1'b0;
                    if (bits_done >= BITS_PER_BYTE)
                    begin
                        rx_last = shifter;
                        sda_en  = 1'b1;
                        sda     = nack_after_read;
                        ph      = ENG_RA_LOW;
                    end
                    else
                    begin
                        ph = ENG_RD_LOW;
                    end
                end
                ENG_RA_LOW:
                begin
                    scl = 1'b1;
                    ph  = ENG_RA_HIGH;
                end
                default:
                begin
                    scl = 1'b0;
                    return 1'b1;
                end
            endcase
            return 1'b0;
        endfunction

        function void start_command(logic [2:0] mode, logic [7:0] tx);
            tick_cnt  = 8'd0;
            bits_done = 4'd0;
            case (mode)
                MODE_START:
                begin
                    sda_en = 1'b1;
                    sda    = 1'b1;
                    scl    = 1'b1;
                    ph     = ENG_ST_HIGH;
                end
                MODE_STOP:
                begin
                    sda_en = 1'b1;
                    scl    = 1'b0;
                    sda    = 1'b0;
                    ph     = ENG_SP_LOW;
                end
                MODE_WRITE:
                begin
                    sda_en  = 1'b1;
                    shifter = tx;
                    load_next_bit();
                end
                MODE_READ_ACK, MODE_READ_NACK:
                begin
                    nack_after_read = (mode == MODE_READ_NACK);
                    sda_en          = 1'b0;
                    scl             = 1'b0;
                    shifter         = 8'd0;
                    ph              = ENG_RD_LOW;
                end
                default: ;
            endcase
        endfunction

        // Advance the mirror by one accepted tick and queue the line levels it yields.
        function void note_tick(logic [2:0] mode, logic [7:0] tx, logic sda_now);
            res_t lines;
            bit   finished;
            finished = 1'b0;
            if (ph == ENG_IDLE)
            begin
                start_command(mode, tx);
            end
            else
            begin
                tick_cnt = tick_cnt + 8'd1;
                if (tick_cnt >= half_len())
                begin
                    tick_cnt = 8'd0;
                    finished = step_phase(sda_now);
                    if (finished)
                    begin
                        ph        = ENG_IDLE;
                        bits_done = 4'd0;
                    end
                end
            end
            lines.scl_out   = scl;
            lines.sda_out   = sda;
            lines.sda_drive = sda_en;
            lines.busy_res  = (ph != ENG_IDLE);
            lines.done_res  = finished;
            lines.rx_byte   = rx_last;
            lines.ack_bit   = ack_seen;
            lines_due.push_back(lines);
            ticks_noted++;
        endfunction

        function void compare_field(string name, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                fail_count++;
            end
        endfunction

        function void check_lines(res_t got);
            res_t want;
            if (lines_due.size() == 0)
            begin
                $error("result transfer with no tick outstanding");
                fail_count++;
                return;
            end
            want = lines_due.pop_front();
            compare_field("scl_out", 8'(want.scl_out), 8'(got.scl_out));
            compare_field("sda_out", 8'(want.sda_out), 8'(got.sda_out));
            compare_field("sda_drive", 8'(want.sda_drive), 8'(got.sda_drive));
            compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
            compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
            compare_field("rx_byte", want.rx_byte, got.rx_byte);
            compare_field("ack_bit", 8'(want.ack_bit), 8'(got.ack_bit));
        endfunction

        function bit engine_busy();
            return ph != ENG_IDLE;
        endfunction

        function int pending();
            return lines_due.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    i2cm_tick_if tick_ch();
    i2cm_res_if  res_ch();
    i2cm_cfg_if  cfg_ch();

    i2c_master_bit_engine_unit uut (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (tick_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    bus_line_tracker sb = new();

    // When set, the matching side offers or accepts every cycle with no gaps.
    bit sender_steady;
    bit receiver_steady;

    always #10 clk = ~clk;

    // Gap lengths: mostly none or short, occasionally long.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic logic sda_for(sda_policy_e policy);
        case (policy)
            SDA_ALL_LOW:  return 1'b0;
            SDA_ALL_HIGH: return 1'b1;
            default:      return 1'($urandom_range(0, 1));
        endcase
    endfunction

    // Offer one tick and wait for its transfer. valid is left high on return, so
    // the caller must either send again at once or call park_ticks.
    task automatic send_tick(logic [2:0] mode, logic [7:0] tx, logic sda_now);
        int unsigned gap;
        gap = sender_steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        tick_ch.valid   <= 1'b1;
        tick_ch.mode    <= mode;
        tick_ch.tx_byte <= tx;
        tick_ch.sda_in  <= sda_now;
        @(posedge clk);
        while (!tick_ch.ready) @(posedge clk);
        sb.note_tick(mode, tx, sda_now);
    endtask

    task automatic park_ticks();
        tick_ch.valid <= 1'b0;
    endtask

    // Launch a command on an idle engine and keep ticking until it completes.
    // Filler ticks carry arbitrary modes, which the busy engine must ignore.
    task automatic issue(logic [2:0] mode, logic [7:0] tx, sda_policy_e policy);
        send_tick(mode, tx, sda_for(policy));
        while (sb.engine_busy())
            send_tick(3'($urandom_range(0, 7)), 8'($urandom), sda_for(policy));
    endtask

    task automatic idle_ticks(int unsigned n);
        repeat (n) send_tick(MODE_NONE, 8'($urandom), 1'($urandom_range(0, 1)));
    endtask

    // Registers may only change with the engine idle and every result drained.
    // A result is registered in the cycle after its tick, so a short pause covers the pipe.
    task automatic program_timing(logic [7:0] bit_h, logic [7:0] ack_h, logic [7:0] hold_h,
                                  bit poke_unused);
        logic [CFG_IDX_W-1:0] idx[$];
        logic [7:0]           val[$];
        park_ticks();
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
        idx = '{CFG_BIT_HALF, CFG_ACK_HALF, CFG_START_STOP};
        val = '{bit_h, ack_h, hold_h};
        if (poke_unused)
        begin
            idx.push_back(CFG_UNUSED);
            val.push_back(8'($urandom));
        end
        foreach (idx[k])
        begin
            cfg_ch.valid <= 1'b1;
            cfg_ch.index <= idx[k];
            cfg_ch.data  <= val[k];
            @(posedge clk);
            while (!cfg_ch.ready) @(posedge clk);
            sb.write_reg(idx[k], val[k]);
        end
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    // Mostly complete transactions (start, a few bytes, stop) with random data
    // and bus answers; the rest are lone commands, including stray stops and
    // unused mode codes.
    task automatic random_transaction();
        int unsigned n;
        logic [2:0]  data_mode;
        sender_steady = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 99) < 85)
        begin
            issue(MODE_START, 8'($urandom), SDA_RANDOM);
            n = $urandom_range(1, 4);
            repeat (n)
            begin
                idle_ticks($urandom_range(0, 2));
                data_mode = 3'($urandom_range(MODE_WRITE, MODE_READ_NACK));
                if (data_mode == MODE_WRITE && $urandom_range(0, 99) < 60)
                    issue(data_mode, 8'($urandom), SDA_ALL_LOW);
                else
                    issue(data_mode, 8'($urandom), SDA_RANDOM);
            end
            idle_ticks($urandom_range(0, 2));
            issue(MODE_STOP, 8'($urandom), SDA_RANDOM);
        end
        else
        begin
            issue(3'($urandom_range(0, 7)), 8'($urandom), SDA_RANDOM);
        end
        idle_ticks($urandom_range(0, 3));
    endtask

    task automatic random_phase();
        int unsigned first;
        first = sb.ticks_noted;
        while (sb.ticks_noted - first < RANDOM_TICKS_PER_PHASE)
            random_transaction();
    endtask

    // Sender side: reset, directed commands, then several timing settings with
    // random traffic under each but the longest, which runs a lone stop.
    initial
    begin
        rst_n           <= 1'b0;
        tick_ch.valid   <= 1'b0;
        tick_ch.mode    <= MODE_NONE;
        tick_ch.tx_byte <= 8'd0;
        tick_ch.sda_in  <= 1'b0;
        cfg_ch.valid    <= 1'b0;
        cfg_ch.index    <= CFG_BIT_HALF;
        cfg_ch.data     <= 8'd0;
        sender_steady   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset timing: every command, the byte
        // extremes, ACK and NACK from the slave, reads of all ones and all
        // zeros, and the unused mode codes on an idle engine.
        issue(MODE_START, 8'h00, SDA_RANDOM);
        issue(MODE_WRITE, 8'hFF, SDA_ALL_LOW);
        issue(MODE_WRITE, 8'h00, SDA_ALL_HIGH);
        issue(MODE_WRITE, 8'hA5, SDA_RANDOM);
        issue(MODE_READ_ACK, 8'h00, SDA_ALL_HIGH);
        issue(MODE_READ_NACK, 8'hFF, SDA_ALL_LOW);
        issue(MODE_READ_ACK, 8'h5A, SDA_RANDOM);
        issue(MODE_STOP, 8'h00, SDA_RANDOM);
        issue(MODE_NONE, 8'hFF, SDA_ALL_HIGH);
        issue(MODE_SPARE_LO, 8'h3C, SDA_RANDOM);
        issue(MODE_SPARE_HI, 8'hC3, SDA_RANDOM);
        issue(MODE_STOP, 8'h00, SDA_RANDOM);
        random_phase();

        // Zero in every register must behave as a one-tick duration; the write
        // to the unimplemented index must change nothing.
        program_timing(8'd0, 8'd0, 8'd0, 1'b1);
        issue(MODE_START, 8'h00, SDA_RANDOM);
        issue(MODE_WRITE, 8'h81, SDA_ALL_LOW);
        issue(MODE_READ_NACK, 8'h00, SDA_RANDOM);
        issue(MODE_STOP, 8'h00, SDA_RANDOM);
        random_phase();

        // Longest durations: a lone stop only, since its low hold alone lasts
        // 255 ticks.
        program_timing(8'd255, 8'd255, 8'd255, 1'b0);
        issue(MODE_STOP, 8'h00, SDA_RANDOM);

        program_timing(8'($urandom_range(1, 5)), 8'($urandom_range(1, 5)),
                       8'($urandom_range(1, 5)), 1'b0);
        random_phase();

        program_timing(8'd2, 8'd1, 8'd3, 1'b1);
        random_phase();

        // Drain: wait for every outstanding result, then a few more cycles so any
        // stray extra result would still be caught.
        park_ticks();
        while (sb.pending() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Receiver side: random back-pressure, and once a long hold-off while the
    // sender keeps offering ticks, so the output register fills and the tick
    // input stalls.
    initial
    begin
        int unsigned gap;
        int unsigned results_seen;
        bit          held;
        res_t        got;
        res_ch.ready    <= 1'b0;
        receiver_steady = 1'b0;
        results_seen    = 0;
        held            = 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1) @(posedge clk);
        forever
        begin
            if (!held && results_seen >= HOLD_AFTER_RESULTS)
            begin
                held = 1'b1;
                res_ch.ready <= 1'b0;
                repeat (RECEIVER_HOLD) @(posedge clk);
            end
            gap = receiver_steady ? 0 : pick_gap();
            if (gap > 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid) @(posedge clk);
            got.scl_out   = res_ch.scl_out;
            got.sda_out   = res_ch.sda_out;
            got.sda_drive = res_ch.sda_drive;
            got.busy_res  = res_ch.busy_res;
            got.done_res  = res_ch.done_res;
            got.rx_byte   = res_ch.rx_byte;
            got.ack_bit   = res_ch.ack_bit;
            sb.check_lines(got);
            results_seen++;
            if (results_seen % 50 == 0)
                receiver_steady = ($urandom_range(0, 3) == 0);
        end
    end

    // Watchdog: a run that stops moving on every channel is a failure.
    int unsigned quiet_cycles = 0;

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= HANG_LIMIT)
            begin
                $display("tb: failure");
                $finish;
            end
        end
    end

endmodule
